FILE: hw/rtl/rss_pkg.sv
// shared types and constants for the rgb 3x3 sharpen stencil
package rss_pkg;

  localparam int MAX_WIDTH_DEF = 2048;   // default line store depth
  localparam int CH_W          = 8;      // bits per color channel
  localparam int NUM_CH        = 3;      // blue, green, red lanes
  localparam int PIX_W         = CH_W * NUM_CH;
  localparam int SUM_W         = 12;     // signed range -1020..1275
  localparam int WIDTH_REG_W   = 12;
  localparam int HEIGHT_REG_W  = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int CMP_W         = 17;     // room for a 16-bit count plus one
  localparam int WIDTH_RST     = 2048;
  localparam int HEIGHT_RST    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // blue in the low byte
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // per-word control worked out from the position counters
  typedef struct packed {
    logic primed;     // word completes an output pixel
    logic last_col;   // that pixel ends its row
    logic top;        // output row is the first one
    logic bottom;     // output row is the last one
    logic left_edge;  // output column is the first one
    logic wide;       // frame is more than one pixel wide
    logic eof;        // pixel ends the frame
  } ctl_t;

  // clamped neighborhood of one output pixel
  typedef struct packed {
    pixel_t up;
    pixel_t ctr;
    pixel_t dn;
    pixel_t lft;
    pixel_t rgt;
    logic   eol;
    logic   eof;
  } opnd_t;

endpackage

FILE: hw/rtl/rgb_sharpen_3x3_stencil_top.sv
// top level of the streaming rgb 3x3 sharpen stencil
// Sharpens an rgb image (8 bits per channel) streamed in raster order, one pixel
// per word, with the kernel center 5, edge neighbors -1, corners 0, clamp-to-edge
// borders and each channel saturated to 0..255. After the last pixel of a frame
// send image_width+1 drain words (in_tuser = 1); each output pixel leaves one row
// plus one pixel after its own input word, so every input word yields zero or one
// result word. The block sustains one word per clock on both sides while
// out_tready stays high; a word's result reaches out_tvalid through the line
// store read on the edge that takes in the word completing its neighborhood,
// then the operand stage and the output register.
// Two line stores of MAX_WIDTH x 24 bits, each with one read and one write port,
// hold the two rows above the incoming row; they need no clearing after reset.
// The user must write image_width (reg 0, 0 acts as 1, capped at MAX_WIDTH) and
// image_height (reg 1, 0 acts as 1) only between frames, which is not enforced.
module rgb_sharpen_3x3_stencil_top #(
  parameter int MAX_WIDTH = rss_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rss_pkg::PIX_W-1:0]         in_tdata,   // blue, green, red
  input  logic                              in_tuser,   // drain
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rss_pkg::PIX_W-1:0]         out_tdata,  // blue, green, red
  output logic                              out_tlast,  // end of line
  output logic                              out_tuser,  // end of frame
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = rss_pkg::CMP_W;
  localparam int WW    = rss_pkg::WIDTH_REG_W;
  localparam int HW    = rss_pkg::HEIGHT_REG_W;
  localparam int W_RST = (MAX_WIDTH < rss_pkg::WIDTH_RST) ? MAX_WIDTH : rss_pkg::WIDTH_RST;

  // effective frame size, clamped when written
  logic [WW-1:0]    width_r;
  logic [HW-1:0]    height_r;
  logic [WW-1:0]    cfg_width;

  // position counters
  logic [COL_W-1:0] in_col_r,  in_col_nxt;
  logic [HW-1:0]    in_row_r,  in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0]    out_row_r, out_row_nxt;

  logic             accept;
  logic             col_end;
  logic             row_end;
  rss_pkg::ctl_t    ctl;
  rss_pkg::pixel_t  px;

  logic             opnd_valid;
  logic             opnd_ready;
  rss_pkg::opnd_t   opnd;
  logic [rss_pkg::NUM_CH-1:0][rss_pkg::CH_W-1:0] lane_res;

  // ---------------------------------------------------------------------------
  // register port, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_width = cfg_data[WW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(W_RST);
      height_r <= HW'(rss_pkg::HEIGHT_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        rss_pkg::REG_IMAGE_WIDTH: begin
          if (cfg_width == '0) begin
            width_r <= WW'(1);
          end else if (CW'(cfg_width) > CW'(MAX_WIDTH)) begin
            width_r <= WW'(MAX_WIDTH);
          end else begin
            width_r <= cfg_width;
          end
        end
        rss_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= (cfg_data[HW-1:0] == '0) ? HW'(1) : cfg_data[HW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // position tracking, settled on the accepting edge
  // ---------------------------------------------------------------------------
  assign accept = in_tvalid && in_tready;

  // a drain word enters as a black pixel
  assign px = in_tuser ? '0 : rss_pkg::pixel_t'(in_tdata);

  always_comb begin
    col_end = (CW'(in_col_r) + CW'(1)) >= CW'(width_r);
    row_end = (CW'(out_row_r) + CW'(1)) >= CW'(height_r);

    ctl.primed    = (in_row_r >= HW'(2)) || ((in_row_r == HW'(1)) && (in_col_r != '0));
    ctl.last_col  = (CW'(out_col_r) + CW'(1)) >= CW'(width_r);
    ctl.top       = (out_row_r == '0);
    ctl.bottom    = row_end;
    ctl.left_edge = (out_col_r == '0);
    ctl.wide      = (width_r != WW'(1));
    ctl.eof       = ctl.last_col && row_end;

    // input side: wrap at row end, row count saturates
    if (col_end) begin
      in_col_nxt = '0;
      in_row_nxt = (in_row_r != '1) ? in_row_r + HW'(1) : in_row_r;
    end else begin
      in_col_nxt = in_col_r + COL_W'(1);
      in_row_nxt = in_row_r;
    end
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    // output side moves only with a result; frame end restarts everything
    if (ctl.primed) begin
      if (ctl.eof) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (ctl.last_col) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores, window and clamped operands
  // ---------------------------------------------------------------------------
  rss_window #(
    .MAX_WIDTH(MAX_WIDTH),
    .COL_W    (COL_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_col  (in_col_r),
    .push_px   (px),
    .push_ctl  (ctl),
    .push_ready(in_tready),
    .opnd_valid(opnd_valid),
    .opnd      (opnd),
    .opnd_ready(opnd_ready)
  );

  // ---------------------------------------------------------------------------
  // one lane per channel, blue in lane 0
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < rss_pkg::NUM_CH; i++) begin : g_lane
    rss_lane u_lane (
      .ctr(opnd.ctr[i*rss_pkg::CH_W +: rss_pkg::CH_W]),
      .up (opnd.up [i*rss_pkg::CH_W +: rss_pkg::CH_W]),
      .dn (opnd.dn [i*rss_pkg::CH_W +: rss_pkg::CH_W]),
      .lft(opnd.lft[i*rss_pkg::CH_W +: rss_pkg::CH_W]),
      .rgt(opnd.rgt[i*rss_pkg::CH_W +: rss_pkg::CH_W]),
      .res(lane_res[i])
    );
  end

  // ---------------------------------------------------------------------------
  // result word register
  // ---------------------------------------------------------------------------
  rss_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_valid(opnd_valid),
    .lane_res  (lane_res),
    .lane_eol  (opnd.eol),
    .lane_eof  (opnd.eof),
    .lane_ready(opnd_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

FILE: hw/rtl/rss_ram.sv
// generic single write port, single read port ram with registered read
module rss_ram #(
  parameter int WIDTH = rss_pkg::PIX_W,
  parameter int DEPTH = rss_pkg::MAX_WIDTH_DEF
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read-first: a same-address write lands after this read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/rss_window.sv
// line stores, 3x3 window and operand stage of the sharpen stencil
module rss_window #(
  parameter int MAX_WIDTH = rss_pkg::MAX_WIDTH_DEF,
  parameter int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [COL_W-1:0]     push_col,
  input  rss_pkg::pixel_t      push_px,
  input  rss_pkg::ctl_t        push_ctl,
  output logic                 push_ready,
  output logic                 opnd_valid,
  output rss_pkg::opnd_t       opnd,
  input  logic                 opnd_ready
);

  // stage 1: word waiting for its line store reads
  logic            v1_r;
  logic [COL_W-1:0] col1_r;
  rss_pkg::pixel_t px1_r;
  rss_pkg::ctl_t   ctl1_r;

  // bypass for a read of the address written on the same edge
  logic            fwd_r;
  rss_pkg::pixel_t fwd_old_r;
  rss_pkg::pixel_t fwd_new_r;

  rss_pkg::pixel_t win_r [0:2][0:2];

  logic            v2_r;
  rss_pkg::opnd_t  opnd_r;
  rss_pkg::opnd_t  opnd_nxt;

  logic            adv1;
  logic            ready2;
  logic [rss_pkg::PIX_W-1:0] rd_older;
  logic [rss_pkg::PIX_W-1:0] rd_newer;
  rss_pkg::pixel_t col0;
  rss_pkg::pixel_t col1;
  logic            left_self;

  assign ready2     = !v2_r || opnd_ready;
  assign adv1       = v1_r && (!ctl1_r.primed || ready2);
  assign push_ready = !v1_r || adv1;

  assign col0 = fwd_r ? fwd_old_r : rss_pkg::pixel_t'(rd_older);
  assign col1 = fwd_r ? fwd_new_r : rss_pkg::pixel_t'(rd_newer);

  rss_ram #(
    .WIDTH(rss_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_older (
    .clk    (clk),
    .wr_en  (adv1),
    .wr_addr(col1_r),
    .wr_data(col1),
    .rd_en  (push),
    .rd_addr(push_col),
    .rd_data(rd_older)
  );

  rss_ram #(
    .WIDTH(rss_pkg::PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_newer (
    .clk    (clk),
    .wr_en  (adv1),
    .wr_addr(col1_r),
    .wr_data(px1_r),
    .rd_en  (push),
    .rd_addr(push_col),
    .rd_data(rd_newer)
  );

  // center column is always the newest column before the shift
  always_comb begin
    left_self    = ctl1_r.last_col ? !ctl1_r.wide : ctl1_r.left_edge;
    opnd_nxt.ctr = win_r[2][1];
    opnd_nxt.up  = ctl1_r.top    ? win_r[2][1] : win_r[2][0];
    opnd_nxt.dn  = ctl1_r.bottom ? win_r[2][1] : win_r[2][2];
    opnd_nxt.lft = left_self ? win_r[2][1] : win_r[1][1];
    opnd_nxt.rgt = ctl1_r.last_col ? win_r[2][1] : col1;
    opnd_nxt.eol = ctl1_r.last_col;
    opnd_nxt.eof = ctl1_r.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else if (push) begin
      v1_r  <= 1'b1;
      fwd_r <= v1_r && adv1 && (col1_r == push_col);
    end else if (adv1) begin
      v1_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      col1_r    <= push_col;
      px1_r     <= push_px;
      ctl1_r    <= push_ctl;
      fwd_old_r <= col1;
      fwd_new_r <= px1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[c][r] <= '0;
        end
      end
    end else if (adv1) begin
      win_r[0]    <= win_r[1];
      win_r[1]    <= win_r[2];
      win_r[2][0] <= col0;
      win_r[2][1] <= col1;
      win_r[2][2] <= px1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv1 && ctl1_r.primed) begin
      v2_r <= 1'b1;
    end else if (opnd_ready) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && ctl1_r.primed) begin
      opnd_r <= opnd_nxt;
    end
  end

  assign opnd_valid = v2_r;
  assign opnd       = opnd_r;

endmodule

FILE: hw/rtl/rss_lane.sv
// one color channel of the sharpen kernel with saturation to 0..255
module rss_lane (
  input  logic [rss_pkg::CH_W-1:0] ctr,
  input  logic [rss_pkg::CH_W-1:0] up,
  input  logic [rss_pkg::CH_W-1:0] dn,
  input  logic [rss_pkg::CH_W-1:0] lft,
  input  logic [rss_pkg::CH_W-1:0] rgt,
  output logic [rss_pkg::CH_W-1:0] res
);

  localparam int SW = rss_pkg::SUM_W;

  logic [SW-1:0] sum;

  // 5*c as (c << 2) + c, two's complement in SUM_W bits
  always_comb begin
    sum = {2'b00, ctr, 2'b00} + SW'(ctr) - SW'(up) - SW'(dn) - SW'(lft) - SW'(rgt);
    if (sum[SW-1]) begin
      res = '0;
    end else if (sum[SW-2:rss_pkg::CH_W] != '0) begin
      res = '1;
    end else begin
      res = sum[rss_pkg::CH_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/rss_merge.sv
// output register that joins the channel lanes into one result word
module rss_merge (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          lane_valid,
  input  logic [rss_pkg::NUM_CH-1:0][rss_pkg::CH_W-1:0] lane_res,
  input  logic                                          lane_eol,
  input  logic                                          lane_eof,
  output logic                                          lane_ready,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [rss_pkg::PIX_W-1:0]                     out_tdata,
  output logic                                          out_tlast,
  output logic                                          out_tuser
);

  logic                      valid_r;
  logic [rss_pkg::PIX_W-1:0] data_r;
  logic                      eol_r;
  logic                      eof_r;

  assign lane_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (lane_ready) begin
      valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ready && lane_valid) begin
      data_r <= lane_res;
      eol_r  <= lane_eol;
      eof_r  <= lane_eof;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = eol_r;
  assign out_tuser  = eof_r;

endmodule

FILE: verif/tb_rgb_sharpen_3x3_stencil_top.sv
// self-checking testbench for the streaming rgb 3x3 sharpen stencil
`timescale 1ns / 100ps

module tb_rgb_sharpen_3x3_stencil_top;

  localparam int LINE_DEPTH   = rss_pkg::MAX_WIDTH_DEF;
  localparam int ROW_CEIL     = 65535;       // input row counter saturates here
  localparam int GAP_MAX      = 13;          // longest idle / stall per word
  localparam int RANDOM_WORDS = 1380;
  localparam int REPORT_CAP   = 60;          // keep the log readable on a bad run
  localparam int DRAIN_LIMIT  = 20000;       // cycles allowed for results to trickle out
  localparam int TAIL_CYCLES  = 10;          // pipeline is three deep, leave some slack
  localparam int RUN_LIMIT_NS = 100_000_000;

  // one sharpened output word as the block should emit it
  typedef struct packed {
    rss_pkg::pixel_t pix;
    logic            eol;
    logic            eof;
  } sharp_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rss_pkg::PIX_W-1:0]        in_tdata = '0;       // blue, green, red
  logic                             in_tuser = 1'b0;     // drain
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rss_pkg::PIX_W-1:0]        out_tdata;           // blue, green, red
  logic                             out_tlast;           // end of line
  logic                             out_tuser;           // end of frame
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rss_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [rss_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  // shadow of the block: registers, line stores, 3x3 window, position counters
  logic [rss_pkg::WIDTH_REG_W-1:0]  width_reg = rss_pkg::WIDTH_REG_W'(rss_pkg::WIDTH_RST);
  logic [rss_pkg::HEIGHT_REG_W-1:0] height_reg = rss_pkg::HEIGHT_REG_W'(rss_pkg::HEIGHT_RST);
  rss_pkg::pixel_t                  older_row [LINE_DEPTH];
  rss_pkg::pixel_t                  newer_row [LINE_DEPTH];
  rss_pkg::pixel_t                  win [3][3];   // [column][row], column 0 oldest, row 0 top
  int                               in_col = 0;
  int                               in_row = 0;
  int                               out_col = 0;
  int                               out_row = 0;

  sharp_word_t                      sharpened_q [$];     // results still owed by the block
  int                               fail_count = 0;
  int                               words_sent = 0;
  bit                               idle_off = 1'b0;     // both sides run flat out while set

  rgb_sharpen_3x3_stencil_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sharpen arithmetic and the streaming position logic
  // ---------------------------------------------------------------------------

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  // center weighted by 5 minus the up, down, left and right neighbors, clipped to a byte
  function automatic logic [7:0] sharpen_lane(input int ctr, input int up, input int dn,
                                              input int lft, input int rgt);
    int s;
    s = 5 * ctr - up - dn - lft - rgt;
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  // advance the shadow by one accepted input word; emit says whether a result leaves
  task automatic sharpen_step(input logic drain, input rss_pkg::pixel_t px_in,
                              output bit emit, output sharp_word_t res);
    int              w, h, k, r;
    rss_pkg::pixel_t px, up, dn, lft, rgt;
    rss_pkg::pixel_t newcol [3];
    rss_pkg::pixel_t c [3];
    bit              primed, last_col, row_end;
    w = eff_width();
    h = eff_height();
    k = in_col;
    px = drain ? '0 : px_in;    // a drain word enters as black
    newcol[0] = older_row[k];
    newcol[1] = newer_row[k];
    newcol[2] = px;
    older_row[k] = newcol[1];
    newer_row[k] = px;
    primed = (in_row >= 2) || (in_row == 1 && k >= 1);
    last_col = (out_col + 1 >= w);
    row_end = primed && last_col;
    // last column of a row: its center is still the newest window column
    if (row_end) begin
      for (r = 0; r < 3; r++) c[r] = win[2][r];
      rgt = c[1];
      lft = (w > 1) ? win[1][1] : c[1];
    end
    for (r = 0; r < 3; r++) begin
      win[0][r] = win[1][r];
      win[1][r] = win[2][r];
      win[2][r] = newcol[r];
    end
    if (!row_end) begin
      for (r = 0; r < 3; r++) c[r] = win[1][r];
      lft = (out_col == 0) ? c[1] : win[0][1];
      rgt = win[2][1];
    end
    // clamp to edge at the top and bottom rows
    up = (out_row == 0) ? c[1] : c[0];
    dn = (out_row + 1 >= h) ? c[1] : c[2];
    res.pix.blue  = sharpen_lane(c[1].blue, up.blue, dn.blue, lft.blue, rgt.blue);
    res.pix.green = sharpen_lane(c[1].green, up.green, dn.green, lft.green, rgt.green);
    res.pix.red   = sharpen_lane(c[1].red, up.red, dn.red, lft.red, rgt.red);
    res.eol = last_col;
    res.eof = last_col && (out_row + 1 >= h);
    emit = primed;
    if (k + 1 >= w) begin
      in_col = 0;
      if (in_row < ROW_CEIL) in_row++;
    end else begin
      in_col = k + 1;
    end
    if (emit) begin
      if (res.eof) begin
        // frame done, next word opens a new one
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
      end else if (last_col) begin
        out_col = 0;
        out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers; every one starts and ends on a falling edge
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    if (idle_off) return 0;
    return $urandom_range(0, GAP_MAX);
  endfunction

  // bias channels toward the saturation corners
  function automatic rss_pkg::pixel_t rand_pixel();
    rss_pkg::pixel_t p;
    p = rss_pkg::pixel_t'(24'($urandom));
    if ($urandom_range(0, 3) == 0) p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 3) == 0) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    if ($urandom_range(0, 3) == 0) p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  // push one input word, then log the result it should cause
  task automatic send_word(input logic drain, input rss_pkg::pixel_t px);
    int          gap;
    bit          emit;
    sharp_word_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= drain;
    do @(posedge clk); while (!in_tready);
    sharpen_step(drain, px, emit, res);
    if (emit) sharpened_q.push_back(res);
    words_sent++;
    @(negedge clk);
  endtask

  // sender holds off until the block has delivered everything owed
  task automatic hold_until_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sharpened_q.size() != 0);
  endtask

  task automatic cfg_write(input rss_pkg::cfg_reg_t idx,
                           input logic [rss_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rss_pkg::REG_IMAGE_WIDTH) width_reg = data[rss_pkg::WIDTH_REG_W-1:0];
    else height_reg = data[rss_pkg::HEIGHT_REG_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // size change only once the block is idle; order of the two writes is random
  task automatic set_frame_size(input logic [rss_pkg::CFG_DATA_W-1:0] w_data,
                                input logic [rss_pkg::CFG_DATA_W-1:0] h_data);
    hold_until_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if ($urandom_range(0, 1)) begin
      cfg_write(rss_pkg::REG_IMAGE_WIDTH, w_data);
      cfg_write(rss_pkg::REG_IMAGE_HEIGHT, h_data);
    end else begin
      cfg_write(rss_pkg::REG_IMAGE_HEIGHT, h_data);
      cfg_write(rss_pkg::REG_IMAGE_WIDTH, w_data);
    end
  endtask

  // one frame of random pixels at the current size plus width+1 trailing words;
  // most of those and a few pixels go in as drains; some drains carry junk data
  task automatic send_random_frame();
    int              pos, area, total;
    logic            drain;
    rss_pkg::pixel_t px;
    area  = eff_width() * eff_height();
    total = area + eff_width() + 1;
    for (pos = 0; pos < total; pos++) begin
      if (pos < area) drain = ($urandom_range(0, 19) == 0);
      else drain = ($urandom_range(0, 7) != 0);
      px = (drain && $urandom_range(0, 1)) ? '0 : rand_pixel();
      send_word(drain, px);
      if (words_sent % 97 == 50) hold_until_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // 3x3 checkerboard: white centers against black neighbors clip high, black
  // centers against white clip low; one pixel goes in as a drain word
  task automatic test_checkerboard_kernel();
    int r, c;
    set_frame_size(16'd3, 16'd3);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if (r == 2 && c == 2) send_word(1'b1, 24'hFFFFFF);
        else send_word(1'b0, ((r + c) % 2 == 0) ? 24'hFFFFFF : 24'h000000);
      end
    end
    // drain words with live-looking data must still act as black
    repeat (4) send_word(1'b1, 24'hFFFFFF);
  endtask

  // zero-size registers act as one; a single column exercises left/right clamps
  task automatic test_degenerate_sizes();
    set_frame_size(16'h0000, 16'h0000);
    send_word(1'b0, 24'h80FF01);
    repeat (2) send_word(1'b1, 24'h000000);
    set_frame_size(16'd1, 16'd3);
    send_word(1'b0, 24'hFF0000);
    send_word(1'b0, 24'h00FF00);
    send_word(1'b0, 24'h0000FF);
    repeat (2) send_word(1'b1, 24'h000000);
  endtask

  // random sizes, mostly small frames, a few wide ones and some single columns
  task automatic test_random_frames();
    int start, w, h, frames, pick;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      frames = $urandom_range(1, 3);
      if (pick == 0) begin
        w = $urandom_range(64, 200);
        h = $urandom_range(1, 2);
        frames = 1;
      end else if (pick == 1) begin
        w = 1;
        h = $urandom_range(1, 20);
      end else begin
        w = $urandom_range(2, 24);
        h = $urandom_range(1, 12);
      end
      // junk in the unused upper width bits; height 1 sometimes written as 0
      set_frame_size({4'($urandom), 12'(w)},
                     (h == 1 && $urandom_range(0, 1)) ? 16'd0 : 16'(h));
      idle_off = ($urandom_range(0, 3) == 0);
      repeat (frames) send_random_frame();
    end
    idle_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, then compare each word with the oldest expectation
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    sharp_word_t     want;
    rss_pkg::pixel_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (sharpened_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $display("%0t: unexpected word, expected none got data %h eol %b eof %b",
                   $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = sharpened_q.pop_front();
        check_field("blue", want.pix.blue, got.blue);
        check_field("green", want.pix.green, got.green);
        check_field("red", want.pix.red, got.red);
        check_field("end of line", 8'(want.eol), 8'(out_tlast));
        check_field("end of frame", 8'(want.eof), 8'(out_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    int r, c, waited;
    for (c = 0; c < 3; c++)
      for (r = 0; r < 3; r++) win[c][r] = '0;
    for (c = 0; c < LINE_DEPTH; c++) begin
      older_row[c] = '0;
      newer_row[c] = '0;
    end
    // synchronous reset held low, then released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_checkerboard_kernel();
    test_degenerate_sizes();
    test_random_frames();

    // let the last results out, bounded
    in_tvalid <= 1'b0;
    waited = 0;
    while (sharpened_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (sharpened_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d expected words never arrived", $time, sharpened_q.size());
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_rgb_sharpen_3x3_stencil_top: PASS");
    end else begin
      $display("tb_rgb_sharpen_3x3_stencil_top: FAIL");
    end
    $finish;
  end

  // hard stop if the handshakes ever hang
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("%0t: run limit reached", $time);
    $display("tb_rgb_sharpen_3x3_stencil_top: FAIL");
    $finish;
  end

endmodule
